// File: rtl/lmdv_pkg.sv
// Shared types and constants for the modulated delay vibrato block.
`default_nettype none
package lmdv_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int PHASE_W    = 32;
    localparam int SWEEP_W    = 25;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DEPTH = 4'd1;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd447392;
    localparam logic [SWEEP_W-1:0] SWEEP_DEPTH_RST = 25'd0;

    // quarter-wave sine polynomial coefficients
    localparam int SIN_A = 51472;
    localparam int SIN_B = 21024;
    localparam int SIN_C = 2320;

    // delay plus three samples, in Q8
    localparam int OFS_W    = 26;
    localparam int OFS_BIAS = 768;
    localparam longint unsigned OFS_MAX =
        ((64'd33554431 * 64'd65535) >> 16) + 64'd768;

    localparam int CNT_W     = 5;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 36;
    localparam int ROUND_Q8 = 128;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_IDX,
        ST_RECIP,
        ST_QEST,
        ST_QFIX,
        ST_Z,
        ST_Z2,
        ST_C,
        ST_INNER,
        ST_MID,
        ST_SINE,
        ST_DELAY,
        ST_MODINIT,
        ST_MOD,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_ACC,
        ST_OUT
    } lmdv_state_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
    } lmdv_qword_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [SWEEP_W-1:0] sweep_depth;
    } lmdv_cfg_t;

endpackage
`default_nettype wire

// File: rtl/lmdv_in_queue.sv
// Front end: accepts input words into a two-entry queue.
`default_nettype none
module lmdv_in_queue
    import lmdv_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_audio_in,
    output lmdv_qword_t                     head,
    input  wire logic                       pop
);

    logic [1:0]                 count_reg, count_next;
    logic signed [SAMPLE_W-1:0] e0_reg, e0_next;
    logic signed [SAMPLE_W-1:0] e1_reg, e1_next;
    logic                       push;

    assign s_ready     = (count_reg != 2'd2);
    assign push        = s_valid && s_ready;
    assign head.valid  = (count_reg != 2'd0);
    assign head.sample = e0_reg;

    always_comb begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                e0_next = s_audio_in;
            end else begin
                e0_next = e1_reg;
                e1_next = s_audio_in;
            end
        end else if (pop) begin
            e0_next    = e1_reg;
            count_next = count_reg - 2'd1;
        end else if (push) begin
            if (count_reg == 2'd0) begin
                e0_next = s_audio_in;
            end else begin
                e1_next = s_audio_in;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule
`default_nettype wire

// File: rtl/lmdv_core.sv
// Back end: LFO, delay arithmetic, ring memory, interpolation and output register.
`default_nettype none
module lmdv_core
    import lmdv_pkg::*;
#(
    parameter int DELAY_DEPTH     = 131072,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lmdv_cfg_t             cfg,
    input  wire lmdv_qword_t           head,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [SAMPLE_W-1:0] m_wet_sample
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int POS_W = AW + 9;
    localparam int IB    = $clog2(SINE_TABLE_SIZE);
    localparam longint unsigned RING8 = longint'(DELAY_DEPTH) * 256;
    localparam longint unsigned MOD_Q = OFS_MAX / RING8;
    localparam int MOD_STEPS = (MOD_Q == 0) ? 1 : $clog2(MOD_Q + 1);
    localparam int MW = ((OFS_W > POS_W) ? OFS_W : POS_W) + MOD_STEPS;
    // floor(2^(32+IB) / size): estimate is at most one below the true phase
    localparam longint unsigned RECIP = (64'd1 << (PHASE_W + IB)) / SINE_TABLE_SIZE;

    localparam logic [IB+PHASE_W-1:0] SIZE_Q  = (IB + PHASE_W)'(SINE_TABLE_SIZE);
    localparam logic [MUL_A_W-1:0]    RECIP_A = MUL_A_W'(RECIP);
    localparam logic [POS_W-1:0] RING8_P = POS_W'(RING8);
    localparam logic [MW-1:0]    RING8_M = MW'(RING8);
    localparam logic [AW-1:0]    LAST_A  = AW'(DELAY_DEPTH - 1);

    lmdv_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [AW-1:0]              wi_reg, wi_next;
    logic                       wrapped_reg, wrapped_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [IB-1:0]              drem_reg, drem_next;
    logic [PHASE_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [15:0]                z15_reg, z15_next;
    logic [15:0]                z2_reg, z2_next;
    logic                       neg_reg, neg_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [OFS_W-1:0]           ofs_reg, ofs_next;
    logic [AW-1:0]              prev_reg, prev_next;
    logic [AW-1:0]              nxt_reg, nxt_next;
    logic [7:0]                 frac_reg, frac_next;
    logic                       prev_ok_reg, prev_ok_next;
    logic                       nxt_ok_reg, nxt_ok_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] out_reg, out_next;

    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [SAMPLE_W-1:0]        mem [DELAY_DEPTH];
    logic                       mem_re, mem_we;
    logic [AW-1:0]              mem_raddr;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;

    logic [IB+PHASE_W-1:0]      qrem;
    logic [30:0]                zval;
    logic [14:0]                inner;
    logic [15:0]                mid;
    logic [15:0]                smag;
    logic [14:0]                sclip;
    logic [MW-1:0]              ring_sh;
    logic [POS_W-1:0]           pos_sum, pos_mod;
    logic [AW-1:0]              prev_c, nxt_c;
    logic signed [SAMPLE_W-1:0] tap_val;
    logic [8:0]                 wt;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-9:0]    acc_sh;

    assign prod_full    = mul_a * mul_b;
    assign m_valid      = m_valid_reg;
    assign m_wet_sample = out_reg;

    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        phase_next   = phase_reg;
        wi_next      = wi_reg;
        wrapped_next = wrapped_reg;
        prod_next    = prod_reg;
        drem_next    = drem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        z15_next     = z15_reg;
        z2_next      = z2_reg;
        neg_next     = neg_reg;
        gain_next    = gain_reg;
        ofs_next     = ofs_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        frac_next    = frac_reg;
        prev_ok_next = prev_ok_reg;
        nxt_ok_next  = nxt_ok_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pop          = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_raddr    = prev_reg;
        mul_a        = '0;
        mul_b        = '0;
        qrem         = '0;
        zval         = '0;
        inner        = '0;
        mid          = '0;
        smag         = prod_reg[30:15];
        sclip        = '0;
        ring_sh      = RING8_M << cnt_reg;
        pos_sum      = '0;
        pos_mod      = '0;
        prev_c       = '0;
        nxt_c        = '0;
        tap_val      = '0;
        wt           = '0;
        acc_sum      = '0;
        acc_sh       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop         = 1'b1;
                    sample_next = head.sample;
                    state_next  = ST_IDX;
                end
            end
            ST_IDX: begin
                mul_a      = {2'b00, phase_reg};
                mul_b      = MUL_B_W'(SINE_TABLE_SIZE);
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                // table index, then its start phase k * 2^32 / size by reciprocal
                drem_next  = prod_reg[32 +: IB];
                mul_a      = RECIP_A;
                mul_b      = MUL_B_W'(prod_reg[32 +: IB]);
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_QEST;
            end
            ST_QEST: begin
                quo_next   = prod_reg[IB +: PHASE_W];
                mul_a      = {2'b00, prod_reg[IB +: PHASE_W]};
                mul_b      = MUL_B_W'(SINE_TABLE_SIZE);
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_QFIX;
            end
            ST_QFIX: begin
                // estimate may be one short: bump it if a whole divisor is left
                qrem = {drem_reg, {PHASE_W{1'b0}}} - prod_reg[IB+PHASE_W-1:0];
                if (qrem >= SIZE_Q) begin
                    quo_next = quo_reg + PHASE_W'(1);
                end
                state_next = ST_Z;
            end
            ST_Z: begin
                // fold into the first quadrant
                if (quo_reg[30]) begin
                    zval = 31'h4000_0000 - {1'b0, quo_reg[29:0]};
                end else begin
                    zval = {1'b0, quo_reg[29:0]};
                end
                z15_next   = zval[30:15];
                neg_next   = quo_reg[31];
                state_next = ST_Z2;
            end
            ST_Z2: begin
                mul_a      = {18'd0, z15_reg};
                mul_b      = {2'b00, z15_reg};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_C;
            end
            ST_C: begin
                z2_next    = prod_reg[30:15];
                mul_a      = {18'd0, prod_reg[30:15]};
                mul_b      = MUL_B_W'(SIN_C);
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_INNER;
            end
            ST_INNER: begin
                inner      = 15'(SIN_B) - {3'b000, prod_reg[26:15]};
                mul_a      = {18'd0, z2_reg};
                mul_b      = {3'b000, inner};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_MID;
            end
            ST_MID: begin
                mid        = 16'(SIN_A) - {1'b0, prod_reg[29:15]};
                mul_a      = {18'd0, z15_reg};
                mul_b      = {2'b00, mid};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_SINE;
            end
            ST_SINE: begin
                sclip = (smag > 16'd32767) ? 15'h7FFF : smag[14:0];
                if (neg_reg) begin
                    gain_next = 16'h8000 - {1'b0, sclip};
                end else begin
                    gain_next = 16'h8000 + {1'b0, sclip};
                end
                state_next = ST_DELAY;
            end
            ST_DELAY: begin
                mul_a      = {9'd0, cfg.sweep_depth};
                mul_b      = {2'b00, gain_reg};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_MODINIT;
            end
            ST_MODINIT: begin
                ofs_next   = {1'b0, prod_reg[40:16]} + OFS_W'(OFS_BIAS);
                cnt_next   = CNT_W'(MOD_STEPS - 1);
                state_next = ST_MOD;
            end
            ST_MOD: begin
                // reduce modulo the ring length, one shifted subtract a cycle
                if (MW'(ofs_reg) >= ring_sh) begin
                    ofs_next = OFS_W'(MW'(ofs_reg) - ring_sh);
                end
                if (cnt_reg == '0) begin
                    state_next = ST_POS;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_POS: begin
                pos_sum = {1'b0, wi_reg, 8'h00} + RING8_P - POS_W'(ofs_reg);
                pos_mod = (pos_sum >= RING8_P) ? (pos_sum - RING8_P) : pos_sum;
                prev_c  = pos_mod[8 +: AW];
                nxt_c   = (prev_c == LAST_A) ? '0 : prev_c + 1'b1;
                prev_next    = prev_c;
                nxt_next     = nxt_c;
                frac_next    = pos_mod[7:0];
                // entries not yet written since reset read as zero
                prev_ok_next = wrapped_reg || (prev_c < wi_reg);
                nxt_ok_next  = wrapped_reg || (nxt_c < wi_reg);
                state_next   = ST_RD0;
            end
            ST_RD0: begin
                mem_re     = 1'b1;
                mem_raddr  = prev_reg;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                mem_re     = 1'b1;
                mem_raddr  = nxt_reg;
                tap_val    = prev_ok_reg ? rdata_reg : '0;
                wt         = 9'd256 - {1'b0, frac_reg};
                mul_a      = {{(MUL_A_W-SAMPLE_W){tap_val[SAMPLE_W-1]}}, tap_val};
                mul_b      = {9'd0, wt};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_RD2;
            end
            ST_RD2: begin
                acc_next   = ACC_W'(prod_reg) + ACC_W'(ROUND_Q8);
                tap_val    = nxt_ok_reg ? rdata_reg : '0;
                mul_a      = {{(MUL_A_W-SAMPLE_W){tap_val[SAMPLE_W-1]}}, tap_val};
                mul_b      = {10'd0, frac_reg};
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_sum = acc_reg + ACC_W'(prod_reg);
                acc_sh  = acc_sum[ACC_W-1:8];
                if (acc_sh > 28'sh07F_FFFF) begin
                    res_next = 24'sh7F_FFFF;
                end else if (acc_sh < -28'sh080_0000) begin
                    res_next = -24'sh80_0000;
                end else begin
                    res_next = acc_sh[SAMPLE_W-1:0];
                end
                mem_we = 1'b1;
                if (wi_reg == LAST_A) begin
                    wi_next      = '0;
                    wrapped_next = 1'b1;
                end else begin
                    wi_next = wi_reg + 1'b1;
                end
                phase_next = phase_reg + cfg.phase_step;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            wi_reg      <= wi_next;
            wrapped_reg <= wrapped_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg  <= sample_next;
        prod_reg    <= prod_next;
        drem_reg    <= drem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        z15_reg     <= z15_next;
        z2_reg      <= z2_next;
        neg_reg     <= neg_next;
        gain_reg    <= gain_next;
        ofs_reg     <= ofs_next;
        prev_reg    <= prev_next;
        nxt_reg     <= nxt_next;
        frac_reg    <= frac_next;
        prev_ok_reg <= prev_ok_next;
        nxt_ok_reg  <= nxt_ok_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wi_reg] <= sample_reg;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/lfo_modulated_delay_vibrato.sv
// Top level of the sine-LFO modulated delay vibrato.
`default_nettype none
// Vibrato effect: each 24-bit Q1.23 word on the s_ channel yields one word on
// the m_ channel, read from a ring of DELAY_DEPTH past samples at a position
// swept by a sine LFO and linearly interpolated between the two neighbouring
// taps. In the back end each word passes through the reciprocal multiply and
// one-step correction that turn the table index into its start phase, the
// shared multiplier that evaluates the sine polynomial one product a cycle,
// MOD_STEPS shifted subtracts that reduce the delay modulo the ring length,
// and the single-port ring memory that reads the two taps in turn; it
// finishes one word before it takes the next. A two-word queue in front and
// the output register let input and output stall independently. There is no
// clearing pass after reset: ring entries not yet written since reset read as
// zero. Write configuration only while idle.
module lfo_modulated_delay_vibrato
    import lmdv_pkg::*;
#(
    parameter int DELAY_DEPTH     = 131072,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_audio_in,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_wet_sample,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    lmdv_cfg_t   cfg_reg, cfg_next;
    lmdv_qword_t q_head;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PHASE_STEP:  cfg_next.phase_step  = cfg_data;
                CFG_SWEEP_DEPTH: cfg_next.sweep_depth = cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_step  <= PHASE_STEP_RST;
            cfg_reg.sweep_depth <= SWEEP_DEPTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lmdv_in_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_audio_in (s_audio_in),
        .head       (q_head),
        .pop        (q_pop)
    );

    lmdv_core #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head         (q_head),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_wet_sample (m_wet_sample)
    );

`ifndef NO_ASSERTIONS
    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // back end takes a word only when the queue holds one
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_head.valid |-> !q_pop)
        else $error("pop from empty queue");

    // an accepted word is in the queue on the next cycle
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_head.valid)
        else $error("accepted word missing from queue");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the sine-LFO modulated delay vibrato block.
module tb_top;
    import lmdv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                CLK_HALF       = 6;
    localparam int                RING_LEN       = 131072;
    localparam int                LUT_LEN        = 1024;
    localparam longint unsigned   RING_Q8        = 64'd131072 * 64'd256;
    localparam longint unsigned   TAP_BIAS_Q8    = 64'd768;
    localparam longint unsigned   POLY_A         = 64'd51472;
    localparam longint unsigned   POLY_B         = 64'd21024;
    localparam longint unsigned   POLY_C         = 2320;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd15;
    localparam int                RAND_PHASES    = 12;
    localparam int                PRESSURE_PHASE = 2;
    localparam int                END_WAIT       = 200;
    localparam int                WATCHDOG_LIMIT = 4000;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_audio_in = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0]  m_wet_sample;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    // predictor state
    int                          sine_lut [LUT_LEN];
    logic signed [SAMPLE_W-1:0]  ring_hist [RING_LEN];
    logic [16:0]                 pred_wr_ptr = '0;
    logic [31:0]                 pred_phase  = '0;
    logic [31:0]                 pred_step   = PHASE_STEP_RST;
    logic [24:0]                 pred_sweep  = SWEEP_DEPTH_RST;

    logic signed [SAMPLE_W-1:0]  expected_out [$];
    int                          fails     = 0;
    int                          quiet     = 0;
    bit                          stall_on  = 1'b1;
    bit                          gaps_on   = 1'b1;

    lfo_modulated_delay_vibrato u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_audio_in   (s_audio_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_wet_sample (m_wet_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int sine_q15(input logic [31:0] t);
        logic [1:0]      quad;
        longint unsigned r, z, z15, z2, inner, mid, s;
        quad  = t[31:30];
        r     = 64'(t[29:0]);
        z     = quad[0] ? (64'h4000_0000 - r) : r;
        z15   = z >> 15;
        z2    = (z15 * z15) >> 15;
        inner = POLY_B - ((z2 * POLY_C) >> 15);
        mid   = POLY_A - ((z2 * inner) >> 15);
        s     = (z15 * mid) >> 15;
        if (s > 64'd32767) s = 64'd32767;
        return quad[1] ? -int'(s) : int'(s);
    endfunction

    function automatic longint unsigned lfo_gain();
        return longint'(32768 + sine_lut[pred_phase[31:22]]);
    endfunction

    // read the interpolated tap, then store the new word and step the LFO
    function automatic logic signed [SAMPLE_W-1:0] vibrato_predict(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint unsigned dly_q8, ofs, pos;
        logic [16:0]     prv, nxt;
        int              wt_next, wt_prev;
        longint          acc, res;
        dly_q8  = (64'(pred_sweep) * lfo_gain()) >> 16;
        ofs     = (dly_q8 + TAP_BIAS_Q8) % RING_Q8;
        pos     = (64'({pred_wr_ptr, 8'd0}) + RING_Q8 - ofs) % RING_Q8;
        prv     = pos[24:8];
        nxt     = prv + 17'd1;
        wt_next = int'(pos[7:0]);
        wt_prev = 256 - wt_next;
        acc     = longint'(ring_hist[prv]) * wt_prev
                + longint'(ring_hist[nxt]) * wt_next + 128;
        res     = acc >>> 8;
        if (res > 8388607)  res = 8388607;
        if (res < -8388608) res = -8388608;
        ring_hist[pred_wr_ptr] = x;
        pred_wr_ptr = pred_wr_ptr + 17'd1;
        pred_phase  = pred_phase + pred_step;
        return res[SAMPLE_W-1:0];
    endfunction

    initial begin
        for (int k = 0; k < LUT_LEN; k++) sine_lut[k] = sine_q15(32'(k) << 22);
        for (int k = 0; k < RING_LEN; k++) ring_hist[k] = '0;
    end

    // monitor: track register writes, predict on accepted words, check results
    always @(posedge aclk) begin : monitor
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PHASE_STEP:  pred_step  = cfg_data;
                    CFG_SWEEP_DEPTH: pred_sweep = cfg_data[24:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_out.push_back(vibrato_predict(s_audio_in));
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("wet_sample: word with nothing expected, actual %0d",
                           m_wet_sample);
                    fails++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_wet_sample !== want) begin
                        $error("wet_sample: expected %0d, actual %0d", want, m_wet_sample);
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin : sink_ctl
        int n;
        @(posedge aclk);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_audio_in <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and let every outstanding word come back; the first edge lets
    // the monitor record the last accepted word
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_out.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 24'sh7F_FFFF;
            1:       return -24'sh80_0000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // reset register values: no sweep, so each word comes back three words late
    task automatic test_reset_defaults();
        send_sample(24'sh7F_FFFF);
        send_sample(-24'sh80_0000);
        send_sample(24'sh00_0000);
        send_sample(-24'sh00_0001);
        send_sample(24'sh00_0001);
        send_sample(24'sh7F_FFFF);
        send_sample(-24'sh80_0000);
        send_sample(24'sh2A_AAAA);
    endtask

    // small sweep gives fractional taps between full-scale neighbours
    task automatic test_interpolation();
        wait_idle();
        write_reg(CFG_SWEEP_DEPTH, 32'h0000_01FF);
        write_reg(CFG_PHASE_STEP, 32'h1357_9BDF);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? -24'sh80_0000 : 24'sh7F_FFFF);
    endtask

    // park the LFO at its peak, then push the offset past the ring and onto zero
    task automatic test_ring_edges();
        longint unsigned g, swp;
        wait_idle();
        write_reg(CFG_PHASE_STEP, 32'h4000_0000 - pred_phase);
        send_sample(24'sh12_3456);
        wait_idle();
        write_reg(CFG_PHASE_STEP, 32'h0000_0000);
        write_reg(CFG_SWEEP_DEPTH, 32'h01FF_FFFF);
        send_sample(-24'sh65_4321);
        send_sample(24'sh7F_FFFF);
        send_sample(-24'sh80_0000);
        wait_idle();
        // smallest sweep whose delay plus three taps equals the ring length
        g   = lfo_gain();
        swp = ((RING_Q8 - TAP_BIAS_Q8) * 64'd65536 + g - 64'd1) / g;
        write_reg(CFG_SWEEP_DEPTH, 32'(swp));
        write_reg(CFG_SPARE_IDX, $urandom());
        send_sample(24'sh55_5555);
        send_sample(-24'sh2A_AAAB);
        send_sample(24'sh00_00FF);
    endtask

    task automatic test_random_phases();
        logic [31:0] stp;
        logic [24:0] swp;
        int          n_words;
        bit          last;
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            last = (p == RAND_PHASES - 1);
            case ($urandom_range(0, 5))
                0:       stp = 32'h0000_0000;
                1:       stp = 32'hFFFF_FFFF;
                2:       stp = 32'h8000_0000;
                3, 4:    stp = $urandom_range(1, 32'h0100_0000);
                default: stp = $urandom();
            endcase
            // mostly delays short enough to land on words already written
            case ($urandom_range(0, 7))
                0:       swp = '0;
                1:       swp = 25'h1FF_FFFF;
                2:       swp = 25'($urandom());
                default: swp = 25'($urandom_range(0, 600 * 256));
            endcase
            stall_on = !last && ($urandom_range(0, 4) != 0);
            gaps_on  = !last && ($urandom_range(0, 4) != 0);
            write_reg(CFG_PHASE_STEP, stp);
            write_reg(CFG_SWEEP_DEPTH, 32'(swp));
            n_words = $urandom_range(55, 85);
            for (int i = 0; i < n_words; i++) begin
                if (p == PRESSURE_PHASE && i == n_words / 2) wait_idle();
                send_sample(random_sample());
            end
        end
    endtask

    initial begin : run
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_interpolation();
        test_ring_edges();
        test_random_phases();
        wait_idle();
        repeat (END_WAIT) @(posedge aclk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: lfo_modulated_delay_vibrato.f
rtl/lmdv_pkg.sv
rtl/lmdv_in_queue.sv
rtl/lmdv_core.sv
rtl/lfo_modulated_delay_vibrato.sv
sim/tb_top.sv
